FILE: rtl/ptp_pkg.sv
// Shared types, register codes, sizes and rounding helpers of the point projection block.
package ptp_pkg;

    localparam int DIV_STAGES = 32;
    localparam int LAT        = 47;
    localparam int FRAC       = 28;
    localparam int CFG_IDX_W  = 3;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 9;

    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K3  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TANGENTIAL = 3'd7;

    localparam logic [30:0] NORM_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               last;
        logic               zpos;
    } t_side;

    // round half up on a magnitude, drop 28 fraction bits
    function automatic logic [51:0] rnd28(input logic [79:0] p);
        logic [80:0] t;
        t = {1'b0, p} + 81'(64'd1 << (FRAC - 1));
        return t[79:28];
    endfunction

    // apply sign to a rounded magnitude
    function automatic logic signed [52:0] sgnq(input logic [51:0] m, input logic neg);
        logic signed [52:0] s;
        s = $signed({1'b0, m});
        return neg ? -s : s;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

endpackage

FILE: rtl/ptp_if.sv
// Stream and configuration channel interfaces of the point projection block.
interface ptp_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic               last_point;

    modport source (output valid, coord_x, coord_y, coord_z, last_point, input ready);
    modport sink   (input valid, coord_x, coord_y, coord_z, last_point, output ready);
endinterface

interface ptp_pixel_if;
    logic                      valid;
    logic                      ready;
    logic                      write_valid;
    logic [ptp_pkg::COL_W-1:0] column;
    logic [ptp_pkg::ROW_W-1:0] row;
    logic signed [31:0]        point_x;
    logic signed [31:0]        point_y;
    logic signed [31:0]        point_z;
    logic                      frame_end;

    modport source (output valid, write_valid, column, row, point_x, point_y, point_z,
                    frame_end, input ready);
    modport sink   (input valid, write_valid, column, row, point_x, point_y, point_z,
                    frame_end, output ready);
endinterface

interface ptp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ptp_pkg::CFG_IDX_W-1:0] index;
    logic [63:0]                   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/point_to_pixel_projection.sv
// Top level: pipelined pinhole projection of 3D points to pixels with lens distortion.
//
//  channel  | dir | carries
//  ---------+-----+--------------------------------------------------------------
//  i_cfg    | in  | register index, 64-bit write data
//  i_pt     | in  | coord_x, coord_y, coord_z, last_point
//  o_px     | out | write_valid, column, row, point_x/y/z, frame_end
//
//  One point per cycle while the output is not stalled.
//  The pipeline is the 32-stage restoring divider for x/z and y/z,
//  followed by 14 multiply/round stages and the output register.
//  i_rst_n clears the configuration registers and the valid bits, which empties the pipeline.
//  A stalled output freezes the whole pipeline and holds off new requests.
module point_to_pixel_projection #(
    parameter int WIDTH  = 640,
    parameter int HEIGHT = 480
) (
    input logic          i_clk,
    input logic          i_rst_n,
    ptp_cfg_if.sink      i_cfg,
    ptp_point_if.sink    i_pt,
    ptp_pixel_if.source  o_px
);

    localparam int LAT = ptp_pkg::LAT;
    localparam int DVL = ptp_pkg::DIV_STAGES - 1;
    localparam int E1  = 32;
    localparam int E2  = 33;
    localparam int E3  = 34;
    localparam int E4  = 35;
    localparam int E5  = 36;
    localparam int E6  = 37;
    localparam int E7  = 38;
    localparam int E8  = 39;
    localparam int E9  = 40;
    localparam int E10 = 41;

    logic [31:0]        r_fx, r_fy, r_cx, r_cy;
    logic signed [31:0] r_k1, r_k2, r_k3;
    logic [63:0]        r_tan;
    logic signed [31:0] p1, p2;

    logic               en;
    logic [LAT-1:0]     r_vld;
    ptp_pkg::t_side     r_sb [0:LAT-2];
    ptp_pkg::t_side     n_side;

    // divider
    logic [61:0] r_rx [0:DVL];
    logic [61:0] r_ry [0:DVL];
    logic [30:0] r_qx [0:DVL];
    logic [30:0] r_qy [0:DVL];
    logic [31:0] r_dv [0:DVL];
    logic        r_ovx [0:DVL];
    logic        r_ovy [0:DVL];
    logic [61:0] n_rx [0:DVL];
    logic [61:0] n_ry [0:DVL];
    logic [30:0] n_qx [0:DVL];
    logic [30:0] n_qy [0:DVL];
    logic [31:0] n_dv [0:DVL];
    logic        n_ovx [0:DVL];
    logic        n_ovy [0:DVL];

    // carried operands
    logic [30:0]        r_am [E1:E9];
    logic [30:0]        r_bm [E1:E9];
    logic               r_as [E1:E9];
    logic               r_bs [E1:E9];
    logic [30:0]        r_r2 [E2:E4];
    logic signed [36:0] r_k1r2 [E4:E8];
    logic signed [40:0] r_k2r4 [E6:E8];
    logic signed [42:0] r_tas [E5:E10];
    logic signed [42:0] r_tbs [E5:E10];

    logic [61:0]        r_aa_p, r_bb_p, r_ab_p;
    logic [34:0]        r_aa, r_bb;
    logic signed [35:0] r_ab;
    logic [61:0]        r_r4_p;
    logic [62:0]        r_k1_p;
    logic               r_k1_n;
    logic [35:0]        r_ta, r_tb;
    logic signed [36:0] r_ab2;
    logic [34:0]        r_r4;
    logic [67:0]        r_t1_p, r_t2_p, r_t3_p, r_t4_p;
    logic               r_t1_n, r_t2_n, r_t3_n, r_t4_n;
    logic [65:0]        r_r6_p;
    logic [66:0]        r_k2_p;
    logic               r_k2_n;
    logic [38:0]        r_r6;
    logic [42:0]        r_k3h_p;
    logic [59:0]        r_k3l_p;
    logic               r_k3_n;
    logic signed [44:0] r_k3r6;
    logic signed [45:0] r_rad;
    logic [47:0]        r_arh_p, r_brh_p;
    logic [58:0]        r_arl_p, r_brl_p;
    logic               r_ar_n, r_br_n;
    logic signed [50:0] r_ad, r_bd;
    logic signed [36:0] r_adc, r_bdc;
    logic [67:0]        r_fu_p, r_fv_p;
    logic               r_fu_n, r_fv_n;
    logic signed [42:0] r_u, r_v;

    logic                      r_wv, r_last;
    logic [ptp_pkg::COL_W-1:0] r_col;
    logic [ptp_pkg::ROW_W-1:0] r_row;
    logic signed [31:0]        r_ox, r_oy, r_oz;

    logic [30:0]        am0, bm0;
    logic [51:0]        r2_raw;
    logic [44:0]        rad_m;
    logic [43:0]        pu, pv;
    logic               okc, okr, wv;
    logic signed [50:0] ad_clip, bd_clip;

    assign p1 = $signed(r_tan[31:0]);
    assign p2 = $signed(r_tan[63:32]);

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx  <= '0;
            r_fy  <= '0;
            r_cx  <= '0;
            r_cy  <= '0;
            r_k1  <= '0;
            r_k2  <= '0;
            r_k3  <= '0;
            r_tan <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                ptp_pkg::REG_FOCAL_X:    r_fx  <= i_cfg.data[31:0];
                ptp_pkg::REG_FOCAL_Y:    r_fy  <= i_cfg.data[31:0];
                ptp_pkg::REG_CENTER_X:   r_cx  <= i_cfg.data[31:0];
                ptp_pkg::REG_CENTER_Y:   r_cy  <= i_cfg.data[31:0];
                ptp_pkg::REG_RADIAL_K1:  r_k1  <= $signed(i_cfg.data[31:0]);
                ptp_pkg::REG_RADIAL_K2:  r_k2  <= $signed(i_cfg.data[31:0]);
                ptp_pkg::REG_RADIAL_K3:  r_k3  <= $signed(i_cfg.data[31:0]);
                ptp_pkg::REG_TANGENTIAL: r_tan <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // pipeline control
    assign en         = !r_vld[LAT-1] || o_px.ready;
    assign i_pt.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_pt.valid};
        end
    end

    always_comb begin
        n_side.x    = i_pt.coord_x;
        n_side.y    = i_pt.coord_y;
        n_side.z    = i_pt.coord_z;
        n_side.last = i_pt.last_point;
        n_side.zpos = (i_pt.coord_z > 32'sd0);
    end

    // restoring divider: stage 0 flags overflow, each later stage adds one quotient bit
    always_comb begin
        logic [30:0] dd;
        logic [31:0] dv;
        logic [61:0] nx, ny;
        logic [63:0] tx, ty, sd;
        dd = n_side.zpos ? i_pt.coord_z[30:0] : 31'd1;
        dv = {dd, 1'b0};
        nx = 62'({32'(ptp_pkg::mag64(64'(i_pt.coord_x))), 29'd0}) + 62'(dd);
        ny = 62'({32'(ptp_pkg::mag64(64'(i_pt.coord_y))), 29'd0}) + 62'(dd);
        n_rx[0]  = nx;
        n_ry[0]  = ny;
        n_qx[0]  = '0;
        n_qy[0]  = '0;
        n_dv[0]  = dv;
        n_ovx[0] = (63'(nx) >= {dv, 31'd0});
        n_ovy[0] = (63'(ny) >= {dv, 31'd0});
        for (int j = 1; j <= DVL; j++) begin
            sd = 64'(r_dv[j-1]) << (DVL - j);
            tx = 64'(r_rx[j-1]) - sd;
            ty = 64'(r_ry[j-1]) - sd;
            n_rx[j]  = tx[63] ? r_rx[j-1] : tx[61:0];
            n_ry[j]  = ty[63] ? r_ry[j-1] : ty[61:0];
            n_qx[j]  = r_qx[j-1];
            n_qy[j]  = r_qy[j-1];
            n_qx[j][DVL-j] = !tx[63];
            n_qy[j][DVL-j] = !ty[63];
            n_dv[j]  = r_dv[j-1];
            n_ovx[j] = r_ovx[j-1];
            n_ovy[j] = r_ovy[j-1];
        end
    end

    assign am0 = r_ovx[DVL] ? ptp_pkg::NORM_MAX : r_qx[DVL];
    assign bm0 = r_ovy[DVL] ? ptp_pkg::NORM_MAX : r_qy[DVL];

    assign r2_raw = ptp_pkg::rnd28(80'(63'(r_aa_p) + 63'(r_bb_p)));

    assign rad_m = 45'(ptp_pkg::mag64(64'(r_rad)));

    assign ad_clip = (r_ad > 51'sd34359738368)  ?  51'sd34359738368 :
                     (r_ad < -51'sd34359738368) ? -51'sd34359738368 : r_ad;
    assign bd_clip = (r_bd > 51'sd34359738368)  ?  51'sd34359738368 :
                     (r_bd < -51'sd34359738368) ? -51'sd34359738368 : r_bd;

    // pixel rounding and frame test
    assign pu  = 44'(r_u) + 44'd32768;
    assign pv  = 44'(r_v) + 44'd32768;
    assign okc = r_u[42] ? (r_u > -43'sd32768) : (32'(pu[42:16]) < 32'(WIDTH));
    assign okr = r_v[42] ? (r_v > -43'sd32768) : (32'(pv[42:16]) < 32'(HEIGHT));
    assign wv  = r_sb[LAT-2].zpos && okc && okr;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= n_side;
            for (int k = 1; k <= LAT - 2; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
            for (int j = 0; j <= DVL; j++) begin
                r_rx[j]  <= n_rx[j];
                r_ry[j]  <= n_ry[j];
                r_qx[j]  <= n_qx[j];
                r_qy[j]  <= n_qy[j];
                r_dv[j]  <= n_dv[j];
                r_ovx[j] <= n_ovx[j];
                r_ovy[j] <= n_ovy[j];
            end

            // E1: normalised ray, squares and cross product
            r_am[E1] <= am0;
            r_bm[E1] <= bm0;
            r_as[E1] <= r_sb[DVL].x[31];
            r_bs[E1] <= r_sb[DVL].y[31];
            r_aa_p   <= 62'(am0) * 62'(am0);
            r_bb_p   <= 62'(bm0) * 62'(bm0);
            r_ab_p   <= 62'(am0) * 62'(bm0);
            for (int k = E2; k <= E9; k++) begin
                r_am[k] <= r_am[k-1];
                r_bm[k] <= r_bm[k-1];
                r_as[k] <= r_as[k-1];
                r_bs[k] <= r_bs[k-1];
            end

            // E2: r2 and Q28 products
            r_r2[E2] <= (r2_raw > 52'(ptp_pkg::NORM_MAX)) ? ptp_pkg::NORM_MAX : r2_raw[30:0];
            r_aa     <= 35'(ptp_pkg::rnd28(80'(r_aa_p)));
            r_bb     <= 35'(ptp_pkg::rnd28(80'(r_bb_p)));
            r_ab     <= 36'(ptp_pkg::sgnq(ptp_pkg::rnd28(80'(r_ab_p)), r_as[E1] ^ r_bs[E1]));
            r_r2[E3] <= r_r2[E2];
            r_r2[E4] <= r_r2[E3];

            // E3
            r_r4_p <= 62'(r_r2[E2]) * 62'(r_r2[E2]);
            r_k1_p <= 63'(32'(ptp_pkg::mag64(64'(r_k1)))) * 63'(r_r2[E2]);
            r_k1_n <= r_k1[31];
            r_ta   <= 36'(r_r2[E2]) + {r_aa, 1'b0};
            r_tb   <= 36'(r_r2[E2]) + {r_bb, 1'b0};
            r_ab2  <= {r_ab, 1'b0};

            // E4
            r_r4       <= 35'(ptp_pkg::rnd28(80'(r_r4_p)));
            r_k1r2[E4] <= 37'(ptp_pkg::sgnq(ptp_pkg::rnd28(80'(r_k1_p)), r_k1_n));
            r_t1_p <= 68'(32'(ptp_pkg::mag64(64'(p1))))
                      * 68'(36'(ptp_pkg::mag64(64'(r_ab2))));
            r_t1_n <= p1[31] ^ r_ab2[36];
            r_t2_p <= 68'(32'(ptp_pkg::mag64(64'(p2)))) * 68'(r_ta);
            r_t2_n <= p2[31];
            r_t3_p <= 68'(32'(ptp_pkg::mag64(64'(p1)))) * 68'(r_tb);
            r_t3_n <= p1[31];
            r_t4_p <= 68'(32'(ptp_pkg::mag64(64'(p2))))
                      * 68'(36'(ptp_pkg::mag64(64'(r_ab2))));
            r_t4_n <= p2[31] ^ r_ab2[36];
            for (int k = E5; k <= E8; k++) begin
                r_k1r2[k] <= r_k1r2[k-1];
            end

            // E5
            r_r6_p <= 66'(r_r4) * 66'(r_r2[E4]);
            r_k2_p <= 67'(32'(ptp_pkg::mag64(64'(r_k2)))) * 67'(r_r4);
            r_k2_n <= r_k2[31];
            r_tas[E5] <= 43'(ptp_pkg::sgnq(ptp_pkg::rnd28(80'(r_t1_p)), r_t1_n))
                       + 43'(ptp_pkg::sgnq(ptp_pkg::rnd28(80'(r_t2_p)), r_t2_n));
            r_tbs[E5] <= 43'(ptp_pkg::sgnq(ptp_pkg::rnd28(80'(r_t3_p)), r_t3_n))
                       + 43'(ptp_pkg::sgnq(ptp_pkg::rnd28(80'(r_t4_p)), r_t4_n));
            for (int k = E6; k <= E10; k++) begin
                r_tas[k] <= r_tas[k-1];
                r_tbs[k] <= r_tbs[k-1];
            end

            // E6
            r_r6       <= 39'(ptp_pkg::rnd28(80'(r_r6_p)));
            r_k2r4[E6] <= 41'(ptp_pkg::sgnq(ptp_pkg::rnd28(80'(r_k2_p)), r_k2_n));
            r_k2r4[E7] <= r_k2r4[E6];
            r_k2r4[E8] <= r_k2r4[E7];

            // E7: split r6 at the binary point
            r_k3h_p <= 43'(32'(ptp_pkg::mag64(64'(r_k3)))) * 43'(r_r6[38:28]);
            r_k3l_p <= 60'(32'(ptp_pkg::mag64(64'(r_k3)))) * 60'(r_r6[27:0]);
            r_k3_n  <= r_k3[31];

            // E8
            r_k3r6 <= 45'(ptp_pkg::sgnq(52'(r_k3h_p) + ptp_pkg::rnd28(80'(r_k3l_p)), r_k3_n));

            // E9: radial factor
            r_rad <= 46'sd268435456 + 46'(r_k1r2[E8]) + 46'(r_k2r4[E8]) + 46'(r_k3r6);

            // E10: split the radial factor at the binary point
            r_arh_p <= 48'(r_am[E9]) * 48'(rad_m[44:28]);
            r_arl_p <= 59'(r_am[E9]) * 59'(rad_m[27:0]);
            r_ar_n  <= r_as[E9] ^ r_rad[45];
            r_brh_p <= 48'(r_bm[E9]) * 48'(rad_m[44:28]);
            r_brl_p <= 59'(r_bm[E9]) * 59'(rad_m[27:0]);
            r_br_n  <= r_bs[E9] ^ r_rad[45];

            // E11: distorted coordinates
            r_ad <= 51'(ptp_pkg::sgnq(52'(r_arh_p) + ptp_pkg::rnd28(80'(r_arl_p)), r_ar_n))
                    + 51'(r_tas[E10]);
            r_bd <= 51'(ptp_pkg::sgnq(52'(r_brh_p) + ptp_pkg::rnd28(80'(r_brl_p)), r_br_n))
                    + 51'(r_tbs[E10]);

            // E12
            r_adc <= 37'(ad_clip);
            r_bdc <= 37'(bd_clip);

            // E13
            r_fu_p <= 68'(36'(ptp_pkg::mag64(64'(r_adc)))) * 68'(r_fx);
            r_fu_n <= r_adc[36];
            r_fv_p <= 68'(36'(ptp_pkg::mag64(64'(r_bdc)))) * 68'(r_fy);
            r_fv_n <= r_bdc[36];

            // E14: image plane
            r_u <= 43'(ptp_pkg::sgnq(ptp_pkg::rnd28(80'(r_fu_p)), r_fu_n)) + 43'(r_cx);
            r_v <= 43'(ptp_pkg::sgnq(ptp_pkg::rnd28(80'(r_fv_p)), r_fv_n)) + 43'(r_cy);

            // output register
            r_wv   <= wv;
            r_col  <= wv ? pu[ptp_pkg::COL_W+15:16] : '0;
            r_row  <= wv ? pv[ptp_pkg::ROW_W+15:16] : '0;
            r_ox   <= wv ? r_sb[LAT-2].x : '0;
            r_oy   <= wv ? r_sb[LAT-2].y : '0;
            r_oz   <= wv ? r_sb[LAT-2].z : '0;
            r_last <= r_sb[LAT-2].last;
        end
    end

    assign o_px.valid       = r_vld[LAT-1];
    assign o_px.write_valid = r_wv;
    assign o_px.column      = r_col;
    assign o_px.row         = r_row;
    assign o_px.point_x     = r_ox;
    assign o_px.point_y     = r_oy;
    assign o_px.point_z     = r_oz;
    assign o_px.frame_end   = r_last;

    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en |=> (r_vld[0] == $past(i_pt.valid)))
        else $error("entry valid does not follow accepted request");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT-1] && r_wv) |-> (r_oz > 32'sd0))
        else $error("pixel write without positive depth");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT-1] && !r_wv) |-> (r_col == '0 && r_row == '0 && r_ox == '0))
        else $error("invalid write carries data");

    a_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT-1] && r_wv) |-> (32'(r_col) < 32'(WIDTH) || WIDTH > 1024))
        else $error("column outside frame");

endmodule

FILE: verif/tb_ptp_if.sv
// Probe interface that marks each accepted result of the point projection block.
interface tb_ptp_probe_if;
    logic hit;
endinterface

FILE: verif/tb_point_to_pixel_projection.sv
// Testbench of the point projection block: directed and random points checked against a predictor.
module tb_point_to_pixel_projection;

    typedef struct packed {
        logic        wv;
        logic [9:0]  col;
        logic [8:0]  row;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic        fe;
    } t_pixel;

    logic i_clk;
    logic i_rst_n;

    ptp_cfg_if      cfg_ch ();
    ptp_point_if    pt_ch ();
    ptp_pixel_if    px_ch ();
    tb_ptp_probe_if probe ();

    point_to_pixel_projection #(.WIDTH(640), .HEIGHT(480)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch.sink),
        .i_pt   (pt_ch.sink),
        .o_px   (px_ch.source)
    );

    assign probe.hit = px_ch.valid && px_ch.ready;

    longint unsigned fx, fy, cx, cy;
    logic [31:0]     k1r, k2r, k3r;
    logic [63:0]     tanr;

    t_pixel pixel_q[$];
    int     mismatches;
    int     cycles;
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     hold_off;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic longint sx32(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint unsigned absq(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint mul28(longint p, longint q);
        longint unsigned mp, mq, r;
        mp = absq(p);
        mq = absq(q);
        r = mp * (mq >> 28) + ((mp * (mq & 64'hFFF_FFFF) + 64'h800_0000) >> 28);
        return ((p < 0) != (q < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint div28(longint num, longint den);
        longint unsigned n, d, q;
        longint r;
        n = absq(num) << 28;
        d = den;
        q = (2 * n + d) / (2 * d);
        r = q > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : longint'(q);
        return num < 0 ? -r : r;
    endfunction

    function automatic bit round_pixel(longint w, longint lim, output longint unsigned pix);
        longint unsigned p;
        if (w < 0) begin
            pix = 0;
            return ((absq(w) + 32768) >> 16) == 0;
        end
        p = (longint'(w) + 32768) >> 16;
        pix = p;
        return p < lim;
    endfunction

    function automatic t_pixel project_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                             logic last);
        t_pixel r;
        longint a, b, p1, p2, r2, r4, r6, rad, ab, aa, bb, ad, bd, u, v;
        longint unsigned s, r2u, c, w;
        bit okc, okr;
        r = '0;
        r.fe = last;
        if (sx32(z) > 0) begin
            a = div28(sx32(x), sx32(z));
            b = div28(sx32(y), sx32(z));
            p1 = sx32(tanr[31:0]);
            p2 = sx32(tanr[63:32]);
            s = absq(a) * absq(a) + absq(b) * absq(b);
            r2u = (s + 64'h800_0000) >> 28;
            r2 = r2u > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : longint'(r2u);
            r4 = mul28(r2, r2);
            r6 = mul28(r4, r2);
            rad = (64'sd1 <<< 28) + mul28(sx32(k1r), r2) + mul28(sx32(k2r), r4)
                  + mul28(sx32(k3r), r6);
            ab = mul28(a, b);
            aa = mul28(a, a);
            bb = mul28(b, b);
            ad = mul28(a, rad) + mul28(p1, 2 * ab) + mul28(p2, r2 + 2 * aa);
            bd = mul28(b, rad) + mul28(p1, r2 + 2 * bb) + mul28(p2, 2 * ab);
            if (ad > (64'sd1 <<< 35)) ad = 64'sd1 <<< 35;
            if (ad < -(64'sd1 <<< 35)) ad = -(64'sd1 <<< 35);
            if (bd > (64'sd1 <<< 35)) bd = 64'sd1 <<< 35;
            if (bd < -(64'sd1 <<< 35)) bd = -(64'sd1 <<< 35);
            u = mul28(ad, longint'(fx)) + longint'(cx);
            v = mul28(bd, longint'(fy)) + longint'(cy);
            okc = round_pixel(u, 640, c);
            okr = round_pixel(v, 480, w);
            if (okc && okr) begin
                r.wv = 1'b1;
                r.col = c[9:0];
                r.row = w[8:0];
                r.px = x;
                r.py = y;
                r.pz = z;
            end
        end
        return r;
    endfunction

    task automatic write_reg(logic [ptp_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            ptp_pkg::REG_FOCAL_X:   fx = val[31:0];
            ptp_pkg::REG_FOCAL_Y:   fy = val[31:0];
            ptp_pkg::REG_CENTER_X:  cx = val[31:0];
            ptp_pkg::REG_CENTER_Y:  cy = val[31:0];
            ptp_pkg::REG_RADIAL_K1: k1r = val[31:0];
            ptp_pkg::REG_RADIAL_K2: k2r = val[31:0];
            ptp_pkg::REG_RADIAL_K3: k3r = val[31:0];
            default: tanr = val;
        endcase
    endtask

    task automatic set_camera(logic [31:0] f_x, logic [31:0] f_y, logic [31:0] c_x,
                              logic [31:0] c_y, logic [31:0] d1, logic [31:0] d2,
                              logic [31:0] d3, logic [63:0] tp);
        write_reg(ptp_pkg::REG_FOCAL_X, {32'd0, f_x});
        write_reg(ptp_pkg::REG_FOCAL_Y, {32'd0, f_y});
        write_reg(ptp_pkg::REG_CENTER_X, {32'd0, c_x});
        write_reg(ptp_pkg::REG_CENTER_Y, {32'd0, c_y});
        write_reg(ptp_pkg::REG_RADIAL_K1, {32'd0, d1});
        write_reg(ptp_pkg::REG_RADIAL_K2, {32'd0, d2});
        write_reg(ptp_pkg::REG_RADIAL_K3, {32'd0, d3});
        write_reg(ptp_pkg::REG_TANGENTIAL, tp);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            pt_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_ch.valid      <= 1'b1;
        pt_ch.coord_x    <= x;
        pt_ch.coord_y    <= y;
        pt_ch.coord_z    <= z;
        pt_ch.last_point <= last;
        @(posedge i_clk);
        while (!pt_ch.ready) @(posedge i_clk);
        pixel_q.insert(pixel_q.size(), project_point(x, y, z, last));
    endtask

    task automatic drain();
        pt_ch.valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (ptp_pkg::LAT + 10) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off)
            px_ch.ready <= 1'b0;
        else
            px_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_pixel got, want;
        if (i_rst_n && probe.hit) begin
            got = '{px_ch.write_valid, px_ch.column, px_ch.row, px_ch.point_x,
                    px_ch.point_y, px_ch.point_z, px_ch.frame_end};
            if (pixel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = pixel_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    // random point in a view cone, depth from 0.25 m to 64 m; with noisy set, about one in five is fully random
    task automatic send_random(int n, bit noisy);
        logic [31:0] x, y, z;
        longint zz;
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(9) < 2) begin
                x = $urandom();
                y = $urandom();
                z = $urandom();
            end else begin
                zz = $urandom_range(32'h40_0000, 32'h4000);
                z = 32'(zz);
                x = 32'(longint'($urandom_range(2 * zz)) - zz);
                y = 32'(longint'($urandom_range(2 * zz)) - zz);
            end
            send_point(x, y, z, $urandom_range(15) == 0);
        end
    endtask

    task automatic test_directed();
        set_camera(32'd500 << 16, 32'd500 << 16, 32'd320 << 16, 32'd240 << 16,
                   32'd0, 32'd0, 32'd0, 64'd0);
        send_point(32'd0, 32'd0, 32'h1_0000, 1'b0);
        send_point(32'd0, 32'd0, 32'd0, 1'b1);
        send_point(32'd100, 32'd100, 32'hFFFF_0000, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'd1, 1'b1);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h4_0000, 32'h3_0000, 32'h8_0000, 1'b0);
        send_point(32'hFFFB_0000, 32'hFFFC_0000, 32'h8_0000, 1'b1);
        drain();
        // principal point at the origin: tiny negatives round to column 0
        set_camera(32'd500 << 16, 32'd500 << 16, 32'd0, 32'd0,
                   32'd0, 32'd0, 32'd0, 64'd0);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h10_0000, 1'b0);
        send_point(32'hFFFF_FF00, 32'd0, 32'h1_0000, 1'b0);
        send_point(32'hFFFF_0000, 32'hFFFF_0000, 32'h1_0000, 1'b1);
        drain();
        set_camera(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   64'h8000_0000_7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 1'b0);
        send_point(32'h1_0000, 32'h1_0000, 32'h1_0000, 1'b1);
        drain();
    endtask

    task automatic test_random_phases();
        int idle[4] = '{0, 69, 0, 12};
        int stall[4] = '{0, 0, 69, 12};
        for (int ph = 0; ph < 4; ph++) begin
            set_camera($urandom_range(32'h400_0000, 32'h40_0000),
                       $urandom_range(32'h400_0000, 32'h40_0000),
                       $urandom_range(32'h300_0000), $urandom_range(32'h200_0000),
                       $urandom_range(32'h200_0000) - 32'h100_0000,
                       $urandom_range(32'h100_0000) - 32'h80_0000,
                       $urandom_range(32'h80_0000) - 32'h40_0000,
                       {32'($urandom_range(32'h20_0000) - 32'h10_0000),
                        32'($urandom_range(32'h20_0000) - 32'h10_0000)});
            send_idle_pct = idle[ph];
            recv_stall_pct = stall[ph];
            send_random(200, ph == 3);
            send_idle_pct = 0;
            recv_stall_pct = 0;
            drain();
        end
    endtask

    task automatic test_backpressure();
        set_camera(32'd400 << 16, 32'd400 << 16, 32'd320 << 16, 32'd240 << 16,
                   32'h100_0000, 32'hFF80_0000, 32'd0, 64'h0001_0000_FFFF_0000);
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            send_random(120, 1'b0);
        join
        drain();
    endtask

    initial begin
        mismatches = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        fx = 0; fy = 0; cx = 0; cy = 0;
        k1r = 0; k2r = 0; k3r = 0; tanr = 0;
        i_rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = ptp_pkg::REG_FOCAL_X;
        cfg_ch.data = '0;
        pt_ch.valid = 1'b0;
        pt_ch.coord_x = '0;
        pt_ch.coord_y = '0;
        pt_ch.coord_z = '0;
        pt_ch.last_point = 1'b0;
        px_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phases();
        test_backpressure();
        if (mismatches == 0 && pixel_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

FILE: sim.f
rtl/ptp_pkg.sv
rtl/ptp_if.sv
rtl/point_to_pixel_projection.sv
verif/tb_ptp_if.sv
verif/tb_point_to_pixel_projection.sv
